[rtl/tfn_pkg.sv]
package tfn_pkg;

  localparam int THR_BITS   = 21;
  localparam int SMALL_BITS = 11;   // magnitudes below 2^11 take the degenerate test
  localparam int SQ_BITS    = 24;
  localparam int SCALE_BITS = 30;   // normalised component length
  localparam int SUM_BITS   = 62;
  localparam int ROOT_BITS  = 32;
  localparam int SQRT_STEPS = 32;
  localparam int CROSS_LAT  = 5;
  localparam int NORM_LAT   = 5;

  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } meta_t;

endpackage

[rtl/triangle_face_normal_unit.sv]
// Triangle face normal unit.
// Input channel: in_valid / in_stall carry one triangle (corners a, b, c,
// signed Q11.12) per request. Result channel: out_valid / out_stall carry
// the unit normal in signed Q1.14 and a degenerate flag, one per triangle,
// in input order.
// Configuration: cfg_we writes cfg_wdata into the degenerate threshold;
// write it only while the pipeline is empty.
// Throughput: one triangle per cycle unless out_stall holds the pipeline.
// Latency: 45 + NORMAL_FRAC_BITS register stages, set by the 32-stage
// bitwise square root and the one-bit-per-stage division, plus edge,
// cross product and normalisation stages.
// Reset: synchronous on rst_n low; the pipeline empties and the
// threshold returns to 0.
// Stall: the whole pipeline holds while a result waits under out_stall;
// in_stall is raised in that case, so nothing is lost or repeated.
module triangle_face_normal_unit import tfn_pkg::*; #(
  parameter int COORD_BITS       = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_BITS-1:0]        in_a_x,
  input  logic signed [COORD_BITS-1:0]        in_a_y,
  input  logic signed [COORD_BITS-1:0]        in_a_z,
  input  logic signed [COORD_BITS-1:0]        in_b_x,
  input  logic signed [COORD_BITS-1:0]        in_b_y,
  input  logic signed [COORD_BITS-1:0]        in_b_z,
  input  logic signed [COORD_BITS-1:0]        in_c_x,
  input  logic signed [COORD_BITS-1:0]        in_c_y,
  input  logic signed [COORD_BITS-1:0]        in_c_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [NORMAL_FRAC_BITS+1:0]  out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0]  out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0]  out_normal_z,
  output logic                                out_degenerate,
  input  logic                                cfg_we,
  input  logic        [THR_BITS-1:0]          cfg_wdata
);

  localparam int F     = NORMAL_FRAC_BITS;
  localparam int OW    = F + 2;
  localparam int MAG_W = 2 * COORD_BITS + 2;
  localparam int LAT   = CROSS_LAT + NORM_LAT + SQRT_STEPS + (F + 2) + 1;

  logic                  en;
  logic [LAT-1:0]        vld_r;
  logic [THR_BITS-1:0]   thr_r;

  logic [MAG_W-1:0]      mag [3];
  meta_t                 meta_c, meta_n, meta_s, meta_d;
  logic [SCALE_BITS-1:0] r_n [3];
  logic [SCALE_BITS-1:0] r_s [3];
  logic [SUM_BITS-1:0]   sum;
  logic [ROOT_BITS-1:0]  root;
  logic [F:0]            q [3];
  logic [OW-1:0]         nrm [3];
  logic [OW-1:0]         nx_r, ny_r, nz_r;
  logic                  degen_r;

  assign en       = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= '0;
    end else begin
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk(clk), .en(en),
    .a_x(in_a_x), .a_y(in_a_y), .a_z(in_a_z),
    .b_x(in_b_x), .b_y(in_b_y), .b_z(in_b_z),
    .c_x(in_c_x), .c_y(in_c_y), .c_z(in_c_z),
    .thr(thr_r), .mag_o(mag), .meta_o(meta_c)
  );

  tfn_norm #(.MAG_W(MAG_W)) u_norm (
    .clk(clk), .en(en), .mag_i(mag), .meta_i(meta_c),
    .r_o(r_n), .sum_o(sum), .meta_o(meta_n)
  );

  tfn_sqrt u_sqrt (
    .clk(clk), .en(en), .sum_i(sum), .r_i(r_n), .meta_i(meta_n),
    .root_o(root), .r_o(r_s), .meta_o(meta_s)
  );

  tfn_div #(.NORMAL_FRAC_BITS(F)) u_div (
    .clk(clk), .en(en), .r_i(r_s), .root_i(root), .meta_i(meta_s),
    .q_o(q), .meta_o(meta_d)
  );

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nrm[l] = meta_d.neg[l] ? -OW'(q[l]) : OW'(q[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (meta_d.degen) begin
        nx_r <= '0;
        ny_r <= OW'(1) << F;
        nz_r <= '0;
      end else begin
        nx_r <= nrm[0];
        ny_r <= nrm[1];
        nz_r <= nrm[2];
      end
      degen_r <= meta_d.degen;
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_normal_x   = nx_r;
  assign out_normal_y   = ny_r;
  assign out_normal_z   = nz_r;
  assign out_degenerate = degen_r;

endmodule

[rtl/tfn_cross.sv]
module tfn_cross import tfn_pkg::*; #(
  parameter int COORD_BITS = 24,
  localparam int MAG_W = 2 * COORD_BITS + 2
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_z,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_z,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] c_z,
  input  logic        [THR_BITS-1:0]   thr,
  output logic        [MAG_W-1:0]      mag_o [3],
  output meta_t                        meta_o
);

  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;

  logic signed [EW-1:0]    e1_r [3];
  logic signed [EW-1:0]    e2_r [3];
  logic signed [PW-1:0]    p_r  [6];
  logic        [MAG_W-1:0] m3_r [3];
  logic        [MAG_W-1:0] m4_r [3];
  logic        [MAG_W-1:0] m5_r [3];
  logic        [2:0]       neg3_r, neg4_r;
  logic        [2:0]       small_r;
  logic [2*SMALL_BITS-1:0] sq_r [3];
  meta_t                   meta_r;

  logic signed [PW:0] diff [3];
  logic [SQ_BITS-1:0] sum;

  always_comb begin
    diff[0] = (PW+1)'(p_r[0]) - (PW+1)'(p_r[1]);
    diff[1] = (PW+1)'(p_r[2]) - (PW+1)'(p_r[3]);
    diff[2] = (PW+1)'(p_r[4]) - (PW+1)'(p_r[5]);
    sum = SQ_BITS'(sq_r[0]) + SQ_BITS'(sq_r[1]) + SQ_BITS'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r[0] <= EW'(b_x) - EW'(a_x);
      e1_r[1] <= EW'(b_y) - EW'(a_y);
      e1_r[2] <= EW'(b_z) - EW'(a_z);
      e2_r[0] <= EW'(c_x) - EW'(a_x);
      e2_r[1] <= EW'(c_y) - EW'(a_y);
      e2_r[2] <= EW'(c_z) - EW'(a_z);

      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];

      for (int i = 0; i < 3; i++) begin
        neg3_r[i] <= diff[i][PW];
        m3_r[i]   <= MAG_W'(diff[i][PW] ? -diff[i] : diff[i]);
        small_r[i] <= (m3_r[i][MAG_W-1:SMALL_BITS] == '0);
        sq_r[i]   <= m3_r[i][SMALL_BITS-1:0] * m3_r[i][SMALL_BITS-1:0];
        m4_r[i]   <= m3_r[i];
        m5_r[i]   <= m4_r[i];
      end
      neg4_r <= neg3_r;

      meta_r.neg   <= neg4_r;
      meta_r.degen <= (&small_r) && (sum <= SQ_BITS'(thr));
    end
  end

  assign mag_o  = m5_r;
  assign meta_o = meta_r;

endmodule

[rtl/tfn_norm.sv]
module tfn_norm import tfn_pkg::*; #(
  parameter int MAG_W = 50
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [MAG_W-1:0]      mag_i [3],
  input  meta_t                 meta_i,
  output logic [SCALE_BITS-1:0] r_o [3],
  output logic [SUM_BITS-1:0]   sum_o,
  output meta_t                 meta_o
);

  localparam int K  = (MAG_W + 7) / 8;
  localparam int BW = $clog2(MAG_W + 1);
  localparam int SW = MAG_W + SCALE_BITS;

  logic [MAG_W-1:0]        m1_r [3];
  logic [MAG_W-1:0]        m2_r [3];
  logic [3:0]              cl_r [K];
  logic [BW-1:0]           maxb_r;
  logic [SCALE_BITS-1:0]   r3_r [3];
  logic [SCALE_BITS-1:0]   r4_r [3];
  logic [SCALE_BITS-1:0]   r5_r [3];
  logic [2*SCALE_BITS-1:0] sq_r [3];
  logic [SUM_BITS-1:0]     sum_r;
  meta_t                   meta_r [5];

  logic [K*8-1:0]  or_pad;
  logic [3:0]      cl [K];
  logic [BW-1:0]   maxb;
  logic [SW-1:0]   sh [3];

  // leading one found per byte first, then across bytes
  always_comb begin
    or_pad = (K*8)'(mag_i[0] | mag_i[1] | mag_i[2]);
    for (int k = 0; k < K; k++) begin
      cl[k] = '0;
      for (int j = 0; j < 8; j++) begin
        if (or_pad[k*8+j]) cl[k] = 4'(j + 1);
      end
    end
    maxb = '0;
    for (int k = 0; k < K; k++) begin
      if (cl_r[k] != '0) maxb = BW'(k * 8 + int'(cl_r[k]));
    end
    for (int i = 0; i < 3; i++) begin
      sh[i] = {m2_r[i], {SCALE_BITS{1'b0}}} >> maxb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl_r   <= cl;
      maxb_r <= maxb;
      for (int i = 0; i < 3; i++) begin
        m1_r[i] <= mag_i[i];
        m2_r[i] <= m1_r[i];
        r3_r[i] <= sh[i][SCALE_BITS-1:0];
        sq_r[i] <= r3_r[i] * r3_r[i];
        r4_r[i] <= r3_r[i];
        r5_r[i] <= r4_r[i];
      end
      sum_r <= SUM_BITS'(sq_r[0]) + SUM_BITS'(sq_r[1]) + SUM_BITS'(sq_r[2]);
      meta_r[0] <= meta_i;
      for (int s = 1; s < 5; s++) meta_r[s] <= meta_r[s-1];
    end
  end

  assign r_o    = r5_r;
  assign sum_o  = sum_r;
  assign meta_o = meta_r[4];

endmodule

[rtl/tfn_sqrt.sv]
module tfn_sqrt import tfn_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SUM_BITS-1:0]   sum_i,
  input  logic [SCALE_BITS-1:0] r_i [3],
  input  meta_t                 meta_i,
  output logic [ROOT_BITS-1:0]  root_o,
  output logic [SCALE_BITS-1:0] r_o [3],
  output meta_t                 meta_o
);

  logic [63:0]           s_r   [SQRT_STEPS];
  logic [63:0]           res_r [SQRT_STEPS];
  logic [SCALE_BITS-1:0] rc_r  [SQRT_STEPS][3];
  meta_t                 meta_r [SQRT_STEPS];

  // one bit of the root per stage
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0]           s_in, res_in, t;
    logic [SCALE_BITS-1:0] rc_in [3];
    meta_t                 meta_in;

    if (g == 0) begin : g_first
      assign s_in    = 64'(sum_i);
      assign res_in  = '0;
      assign rc_in   = r_i;
      assign meta_in = meta_i;
    end else begin : g_next
      assign s_in    = s_r[g-1];
      assign res_in  = res_r[g-1];
      assign rc_in   = rc_r[g-1];
      assign meta_in = meta_r[g-1];
    end

    assign t = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (s_in >= t) begin
          s_r[g]   <= s_in - t;
          res_r[g] <= (res_in >> 1) + BIT;
        end else begin
          s_r[g]   <= s_in;
          res_r[g] <= res_in >> 1;
        end
        rc_r[g]   <= rc_in;
        meta_r[g] <= meta_in;
      end
    end
  end

  assign root_o = (res_r[SQRT_STEPS-1] == '0) ? ROOT_BITS'(1)
                                             : res_r[SQRT_STEPS-1][ROOT_BITS-1:0];
  assign r_o    = rc_r[SQRT_STEPS-1];
  assign meta_o = meta_r[SQRT_STEPS-1];

endmodule

[rtl/tfn_div.sv]
module tfn_div import tfn_pkg::*; #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [SCALE_BITS-1:0]       r_i [3],
  input  logic [ROOT_BITS-1:0]        root_i,
  input  meta_t                       meta_i,
  output logic [NORMAL_FRAC_BITS:0]   q_o [3],
  output meta_t                       meta_o
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = SCALE_BITS + F + 2;
  localparam int PWD = ROOT_BITS + 2;
  localparam int DW  = ROOT_BITS + 1;
  localparam int ST  = F + 2;

  logic [PWD-1:0] p_r  [ST][3];
  logic [F:0]     nl_r [ST][3];
  logic [F:0]     q_r  [ST][3];
  logic [DW-1:0]  d_r  [ST];
  meta_t          meta_r [ST];

  logic [NW-1:0] num [3];

  // numerator r*2^(F+1) + L over divisor 2L; top part is already below the divisor
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = (NW'(r_i[l]) << (F + 1)) + NW'(root_i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        p_r[0][l]  <= PWD'(num[l] >> (F + 1));
        nl_r[0][l] <= num[l][F:0];
        q_r[0][l]  <= '0;
      end
      d_r[0]    <= {root_i, 1'b0};
      meta_r[0] <= meta_i;
    end
  end

  for (genvar k = 1; k < ST; k++) begin : g_step
    localparam int J = F + 1 - k;
    logic [PWD-1:0] t [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l] = {p_r[k-1][l][PWD-2:0], nl_r[k-1][l][J]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          nl_r[k][l] <= nl_r[k-1][l];
          if (t[l] >= PWD'(d_r[k-1])) begin
            p_r[k][l]    <= t[l] - PWD'(d_r[k-1]);
            q_r[k][l]    <= q_r[k-1][l] | ((F+1)'(1) << J);
          end else begin
            p_r[k][l]    <= t[l];
            q_r[k][l]    <= q_r[k-1][l];
          end
        end
        d_r[k]    <= d_r[k-1];
        meta_r[k] <= meta_r[k-1];
      end
    end
  end

  assign q_o    = q_r[ST-1];
  assign meta_o = meta_r[ST-1];

endmodule
